FILE: src/utf8ss_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer package
// Shared payload types, byte range limits and register map of the sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8ss_pkg;

  // Byte ranges of the lead and continuation classes.
  localparam logic [7:0] ASCII_HI = 8'h7f;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hbf;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  // Replacement character U+FFFD in UTF-8.
  localparam logic [7:0] REPL_B0 = 8'hef;
  localparam logic [7:0] REPL_B1 = 8'hbf;
  localparam logic [7:0] REPL_B2 = 8'hbd;

  localparam int PEND_DEPTH  = 4;
  localparam int BURST_DEPTH = 7;
  localparam int CNT_W       = 3;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_TRUNCATE_ADDR = 3'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       was_truncated;
  } out_t;

  typedef out_t [BURST_DEPTH-1:0] burst_t;

  // Results produced by one input transaction.
  typedef struct packed {
    burst_t           entries;
    logic [CNT_W-1:0] count;
  } burst_load_t;

endpackage

`default_nettype wire

FILE: src/utf8ss_cfg.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer configuration register
// APB-style access to the truncate_on_error control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ss_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [utf8ss_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [utf8ss_pkg::PDATA_W-1:0]   pwdata,
  output logic      [utf8ss_pkg::PDATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic                                  truncate_on_error
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
                  && (paddr == utf8ss_pkg::REG_TRUNCATE_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      truncate_on_error <= 1'b0;
    end else if (wr_en) begin
      truncate_on_error <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == utf8ss_pkg::REG_TRUNCATE_ADDR) begin
      prdata[0] = truncate_on_error;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8ss_step.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer decode step
// Holds the per-string decode state and builds the result burst of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ss_step (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire utf8ss_pkg::in_t         item,
  input  wire logic                    truncate_on_error,
  output utf8ss_pkg::burst_load_t      load
);

  logic [1:0]                   cont_left;
  logic [1:0]                   cont_left_next;
  logic [utf8ss_pkg::CNT_W-1:0] pend_cnt;
  logic [utf8ss_pkg::CNT_W-1:0] pend_cnt_next;
  logic                         discarding;
  logic                         discarding_next;
  logic [7:0]                   pend      [utf8ss_pkg::PEND_DEPTH];
  logic [7:0]                   pend_next [utf8ss_pkg::PEND_DEPTH];

  logic [7:0]                   b;
  logic                         is_cont;
  logic [utf8ss_pkg::CNT_W-1:0] n_old;
  logic [utf8ss_pkg::CNT_W-1:0] n_new;
  logic [utf8ss_pkg::CNT_W:0]   total_sum;
  logic [utf8ss_pkg::CNT_W-1:0] total;
  logic [utf8ss_pkg::CNT_W:0]   rel_idx;

  // Next decode state.
  always_comb begin
    b               = item.in_byte;
    is_cont         = (b >= utf8ss_pkg::CONT_LO) && (b <= utf8ss_pkg::CONT_HI);
    pend_next       = pend;
    pend_cnt_next   = pend_cnt;
    cont_left_next  = cont_left;
    discarding_next = discarding;
    if (!discarding) begin
      if (cont_left == 2'd0) begin
        // The previous group is released here, so the pending list restarts.
        pend_cnt_next = '0;
        priority if (b <= utf8ss_pkg::ASCII_HI) begin
          pend_next[0]  = b;
          pend_cnt_next = 3'd1;
        end else if ((b >= utf8ss_pkg::LEAD2_LO) && (b <= utf8ss_pkg::LEAD2_HI)) begin
          pend_next[0]   = b;
          pend_cnt_next  = 3'd1;
          cont_left_next = 2'd1;
        end else if ((b >= utf8ss_pkg::LEAD3_LO) && (b <= utf8ss_pkg::LEAD3_HI)) begin
          pend_next[0]   = b;
          pend_cnt_next  = 3'd1;
          cont_left_next = 2'd2;
        end else if ((b >= utf8ss_pkg::LEAD4_LO) && (b <= utf8ss_pkg::LEAD4_HI)) begin
          pend_next[0]   = b;
          pend_cnt_next  = 3'd1;
          cont_left_next = 2'd3;
        end else if (truncate_on_error) begin
          discarding_next = 1'b1;
        end else begin
          pend_next[0]  = utf8ss_pkg::REPL_B0;
          pend_next[1]  = utf8ss_pkg::REPL_B1;
          pend_next[2]  = utf8ss_pkg::REPL_B2;
          pend_cnt_next = 3'd3;
        end
      end else begin
        priority if (is_cont) begin
          if (pend_cnt < 3'(utf8ss_pkg::PEND_DEPTH)) begin
            pend_next[pend_cnt[1:0]] = b;
            pend_cnt_next            = pend_cnt + 3'd1;
          end
          cont_left_next = cont_left - 2'd1;
        end else if (truncate_on_error) begin
          discarding_next = 1'b1;
          pend_cnt_next   = '0;
          cont_left_next  = 2'd0;
        end else begin
          // Broken group: replacement character, then the offending byte raw.
          pend_next[0]   = utf8ss_pkg::REPL_B0;
          pend_next[1]   = utf8ss_pkg::REPL_B1;
          pend_next[2]   = utf8ss_pkg::REPL_B2;
          pend_next[3]   = b;
          pend_cnt_next  = 3'd4;
          cont_left_next = 2'd0;
        end
      end
    end
  end

  // Result burst: old group first, then at end of string the new group.
  always_comb begin
    n_old     = (!discarding && (cont_left == 2'd0)) ? pend_cnt : '0;
    n_new     = (item.in_last && !discarding_next && (cont_left_next == 2'd0))
                ? pend_cnt_next : '0;
    total_sum = {1'b0, n_old} + {1'b0, n_new};
    total     = total_sum[utf8ss_pkg::CNT_W-1:0];
    rel_idx   = '0;
    load      = '0;
    for (int j = 0; j < utf8ss_pkg::BURST_DEPTH; j++) begin
      rel_idx = 4'(j) - {1'b0, n_old};
      if (3'(j) < n_old) begin
        load.entries[j].out_byte = pend[j[1:0]];
      end else begin
        load.entries[j].out_byte = pend_next[rel_idx[1:0]];
      end
      load.entries[j].byte_valid = 1'b1;
    end
    load.count = total;
    if (item.in_last) begin
      if (total == '0) begin
        // Bare end marker.
        load.entries[0] = '0;
        load.entries[0].out_last      = 1'b1;
        load.entries[0].was_truncated = discarding_next;
        load.count = 3'd1;
      end else begin
        load.entries[total - 3'd1].out_last      = 1'b1;
        load.entries[total - 3'd1].was_truncated = discarding_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_left  <= 2'd0;
      pend_cnt   <= '0;
      discarding <= 1'b0;
    end else if (advance) begin
      if (item.in_last) begin
        cont_left  <= 2'd0;
        pend_cnt   <= '0;
        discarding <= 1'b0;
      end else begin
        cont_left  <= cont_left_next;
        pend_cnt   <= pend_cnt_next;
        discarding <= discarding_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pend <= pend_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8ss_obuf.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer output buffer
// Holds one result burst and hands it out one transaction per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ss_obuf (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load_en,
  input  wire utf8ss_pkg::burst_load_t load,
  output logic                         can_load,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output utf8ss_pkg::out_t             out_data
);

  utf8ss_pkg::burst_t           entries;
  logic [utf8ss_pkg::CNT_W-1:0] cnt;
  logic                         pop;

  assign out_valid = (cnt != '0);
  assign out_data  = entries[0];
  assign pop       = out_valid && !out_stall;
  // A new burst may enter once the current one is gone or leaves this cycle.
  assign can_load  = (cnt == '0) || ((cnt == 3'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_en) begin
      cnt <= load.count;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      entries <= load.entries;
    end else if (pop) begin
      for (int j = 0; j < utf8ss_pkg::BURST_DEPTH - 1; j++) begin
        entries[j] <= entries[j+1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8_stream_sanitizer_unit.sv
// Path: a byte is registered at the input, then its results in the result buffer.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_stall is low; a byte that yields several results (up to 7) holds the input
// until the single output port has drained the result buffer to its last result.
// Reset: synchronous rst clears decode state, buffers and truncate_on_error;
// the pending byte store is not cleared and is read only after being written.
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer
// Byte-serial UTF-8 validator that substitutes or truncates on invalid input.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_sanitizer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire utf8ss_pkg::in_t                  in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output utf8ss_pkg::out_t                      out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [utf8ss_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [utf8ss_pkg::PDATA_W-1:0]   pwdata,
  output logic      [utf8ss_pkg::PDATA_W-1:0]   prdata,
  output logic                                  pready
);

  logic                    in_v;
  utf8ss_pkg::in_t         in_item;
  logic                    can_load;
  logic                    advance;
  logic                    truncate_on_error;
  utf8ss_pkg::burst_load_t load;

  assign advance  = in_v && can_load;
  assign in_stall = in_v && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  utf8ss_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .truncate_on_error (truncate_on_error)
  );

  utf8ss_step u_step (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .item              (in_item),
    .truncate_on_error (truncate_on_error),
    .load              (load)
  );

  utf8ss_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load_en   (advance),
    .load      (load),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/utf8ss_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer port checker
// Concurrent checks on the top-level ports, bound to the sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8ss_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire utf8ss_pkg::in_t                  in_data,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire utf8ss_pkg::out_t                 out_data,
  input wire logic                             pready
);

  // A stalled input transaction holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // A result without a byte is only ever the end marker of a string.
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.out_last && (out_data.out_byte == 8'h00))
    else $error("bare result is not a clean end of string");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_truncated |-> out_data.out_last)
    else $error("truncation flag outside the final result");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port not ready");

endmodule

bind utf8_stream_sanitizer_unit utf8ss_checker u_chk (.*);

`default_nettype wire

FILE: tb/sv/utf8_stream_sanitizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer checker
// Watches the byte, result and register ports of the sanitizer. It rebuilds
// the sanitized stream for every accepted input transaction and compares each
// result transaction, field by field, with the oldest byte still due.
// ----------------------------------------------------------------------------

module utf8_stream_sanitizer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  utf8ss_pkg::in_t                in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  utf8ss_pkg::out_t               out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [utf8ss_pkg::PADDR_W-1:0] paddr,
  input  logic [utf8ss_pkg::PDATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             results_due,
  output int                             fail_count
);

  localparam int MAX_REPORTS = 200;

  // Shadow of the decoder state and the truncate register.
  logic       trunc_mode = 1'b0;
  logic [1:0] cont_left = '0;
  logic [7:0] held [utf8ss_pkg::PEND_DEPTH];
  logic [2:0] held_cnt = '0;
  logic       dropping = 1'b0;

  utf8ss_pkg::out_t sanitized_q [$];
  utf8ss_pkg::out_t burst [utf8ss_pkg::BURST_DEPTH];
  int   burst_n;
  int   fails = 0;
  int   reports = 0;

  initial begin
    results_due = 0;
    fail_count  = 0;
  end

  function automatic void push_result(input logic [7:0] b, input logic v);
    burst[burst_n] = '{out_byte: b, byte_valid: v, out_last: 1'b0, was_truncated: 1'b0};
    burst_n++;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) push_result(held[i], 1'b1);
    held_cnt = '0;
  endfunction

  function automatic void load_replacement();
    held[0]  = utf8ss_pkg::REPL_B0;
    held[1]  = utf8ss_pkg::REPL_B1;
    held[2]  = utf8ss_pkg::REPL_B2;
    held_cnt = 3'd3;
  endfunction

  // Works out every output byte that one input byte releases.
  function automatic void sanitize_byte(input logic [7:0] b, input logic last);
    int need;
    burst_n = 0;
    if (!dropping) begin
      if (cont_left == 2'd0) begin
        flush_held();
        if (b <= utf8ss_pkg::ASCII_HI) need = 0;
        else if (b >= utf8ss_pkg::LEAD2_LO && b <= utf8ss_pkg::LEAD2_HI) need = 1;
        else if (b >= utf8ss_pkg::LEAD3_LO && b <= utf8ss_pkg::LEAD3_HI) need = 2;
        else if (b >= utf8ss_pkg::LEAD4_LO && b <= utf8ss_pkg::LEAD4_HI) need = 3;
        else need = -1;
        if (need >= 0) begin
          held[0]   = b;
          held_cnt  = 3'd1;
          cont_left = need[1:0];
        end else if (trunc_mode) begin
          dropping = 1'b1;
        end else begin
          load_replacement();
        end
      end else if (b >= utf8ss_pkg::CONT_LO && b <= utf8ss_pkg::CONT_HI) begin
        if (held_cnt < utf8ss_pkg::PEND_DEPTH) begin
          held[held_cnt[1:0]] = b;
          held_cnt++;
        end
        cont_left = cont_left - 2'd1;
      end else if (trunc_mode) begin
        // An error inside a group drops the partial group as well.
        dropping  = 1'b1;
        held_cnt  = '0;
        cont_left = '0;
      end else begin
        load_replacement();
        held[3]   = b;
        held_cnt  = 3'd4;
        cont_left = '0;
      end
    end

    if (last) begin
      if (!dropping && cont_left == 2'd0) flush_held();
      if (burst_n == 0) push_result(8'h00, 1'b0);
      burst[burst_n-1].out_last      = 1'b1;
      burst[burst_n-1].was_truncated = dropping;
      cont_left = '0;
      held_cnt  = '0;
      dropping  = 1'b0;
    end

    for (int i = 0; i < burst_n; i++) sanitized_q.insert(sanitized_q.size(), burst[i]);
  endfunction

  always @(posedge clk) begin
    utf8ss_pkg::out_t want;
    if (rst) begin
      trunc_mode = 1'b0;
      cont_left  = '0;
      held_cnt   = '0;
      dropping   = 1'b0;
      sanitized_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == utf8ss_pkg::REG_TRUNCATE_ADDR)
        trunc_mode = pwdata[0];

      if (in_valid && !in_stall) sanitize_byte(in_data.in_byte, in_data.in_last);

      if (out_valid && !out_stall) begin
        if (sanitized_q.size() == 0) begin
          fails++;
          if (reports < MAX_REPORTS)
            $display("%0t: unexpected result: expected none, got byte %h valid %b last %b trunc %b",
                     $time, out_data.out_byte, out_data.byte_valid, out_data.out_last,
                     out_data.was_truncated);
          reports++;
        end else begin
          want = sanitized_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.byte_valid !== want.byte_valid ||
              out_data.out_last !== want.out_last ||
              out_data.was_truncated !== want.was_truncated) begin
            fails++;
            if (reports < MAX_REPORTS)
              $display({"%0t: result mismatch: expected byte %h valid %b last %b trunc %b,",
                        " got byte %h valid %b last %b trunc %b"},
                       $time, want.out_byte, want.byte_valid, want.out_last,
                       want.was_truncated, out_data.out_byte, out_data.byte_valid,
                       out_data.out_last, out_data.was_truncated);
            reports++;
          end
        end
      end
    end
    results_due <= sanitized_q.size();
    fail_count  <= fails;
  end

endmodule

FILE: tb/sv/utf8_stream_sanitizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream sanitizer testbench
// Drives directed and random byte strings through the sanitizer in both
// substitute and truncate mode, with random idle bursts on both channels and
// a long output hold-off, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------

module utf8_stream_sanitizer_unit_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  utf8ss_pkg::in_t                in_data;
  logic                           out_valid;
  logic                           out_stall;
  utf8ss_pkg::out_t               out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [utf8ss_pkg::PADDR_W-1:0] paddr;
  logic [utf8ss_pkg::PDATA_W-1:0] pwdata;
  logic [utf8ss_pkg::PDATA_W-1:0] prdata;
  logic                           pready;
  int                             results_due;
  int                             fail_count;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold_req = 1'b0;
  int bytes_sent = 0;
  int cycle_count = 0;

  utf8_stream_sanitizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  utf8_stream_sanitizer_checker sanitizer_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    int hold_cycles;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_stall     <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_range(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] v;
    v = 8'($urandom_range(hi, lo));
    return v;
  endfunction

  task automatic write_reg(input logic [utf8ss_pkg::PADDR_W-1:0] addr,
                           input logic [utf8ss_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    in_data  <= '{in_byte: b, in_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_seq(input logic [7:0] s[$], input logic end_string);
    for (int i = 0; i < s.size(); i++) put_byte(s[i], end_string && i == s.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // A byte may still be in flight with no result of its own, so let the
  // pipeline settle before touching the register.
  task automatic settle();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed characters with random content, with some invalid
  // leads, cut-short groups and raw noise mixed in.
  task automatic send_random_string(input int max_chars);
    logic [7:0] str [$];
    int n_chars;
    int kind;
    int n_cont;
    n_chars = $urandom_range(1, max_chars);
    for (int c = 0; c < n_chars; c++) begin
      kind   = $urandom_range(0, 99);
      n_cont = 0;
      if (kind < 30) begin
        str.insert(str.size(), rand_range(8'h00, utf8ss_pkg::ASCII_HI));
      end else if (kind < 48) begin
        str.insert(str.size(), rand_range(utf8ss_pkg::LEAD2_LO, utf8ss_pkg::LEAD2_HI));
        n_cont = 1;
      end else if (kind < 66) begin
        str.insert(str.size(), rand_range(utf8ss_pkg::LEAD3_LO, utf8ss_pkg::LEAD3_HI));
        n_cont = 2;
      end else if (kind < 82) begin
        str.insert(str.size(), rand_range(utf8ss_pkg::LEAD4_LO, utf8ss_pkg::LEAD4_HI));
        n_cont = 3;
      end else if (kind < 88) begin
        case ($urandom_range(0, 2))
          0: str.insert(str.size(), rand_range(utf8ss_pkg::CONT_LO, utf8ss_pkg::CONT_HI));
          1: str.insert(str.size(), rand_range(utf8ss_pkg::LEAD2_LO - 8'd2,
                                               utf8ss_pkg::LEAD2_LO - 8'd1));
          default: str.insert(str.size(), rand_range(utf8ss_pkg::LEAD4_HI + 8'd1, 8'hff));
        endcase
      end else if (kind < 94) begin
        str.insert(str.size(), rand_range(utf8ss_pkg::LEAD3_LO, utf8ss_pkg::LEAD4_HI));
        n_cont = $urandom_range(0, 1);
      end else begin
        str.insert(str.size(), rand_range(8'h00, 8'hff));
      end
      repeat (n_cont) str.insert(str.size(), rand_range(utf8ss_pkg::CONT_LO,
                                                         utf8ss_pkg::CONT_HI));
    end
    send_seq(str, 1'b1);
  endtask

  initial begin
    logic [7:0] seq [$];
    logic [utf8ss_pkg::PDATA_W-1:0] word;
    int goal;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Substitute mode: range extremes, groups of one, two and four bytes, an invalid
    // lead, a broken group, and strings that end with a group still open.
    seq = '{8'h00, utf8ss_pkg::ASCII_HI, utf8ss_pkg::LEAD2_HI, utf8ss_pkg::CONT_HI,
            utf8ss_pkg::LEAD4_HI, utf8ss_pkg::CONT_LO, utf8ss_pkg::CONT_LO,
            utf8ss_pkg::CONT_HI};
    send_seq(seq, 1'b1);
    seq = '{8'hff, utf8ss_pkg::LEAD3_LO, 8'h41, utf8ss_pkg::LEAD2_LO};
    send_seq(seq, 1'b1);
    seq = '{utf8ss_pkg::LEAD2_LO - 8'd1};
    send_seq(seq, 1'b1);
    seq = '{utf8ss_pkg::LEAD3_LO};
    send_seq(seq, 1'b1);

    // Truncate mode: an error on a lead byte, then one inside a group. The
    // register is cleared mid-string while output is already cut off.
    settle();
    write_reg(utf8ss_pkg::REG_TRUNCATE_ADDR, 32'd1);
    seq = '{8'h41, utf8ss_pkg::LEAD4_HI + 8'd1, 8'h42};
    send_seq(seq, 1'b1);
    seq = '{utf8ss_pkg::LEAD3_LO, utf8ss_pkg::CONT_LO, 8'h30, 8'h31};
    send_seq(seq, 1'b0);
    settle();
    write_reg(utf8ss_pkg::REG_TRUNCATE_ADDR, 32'd0);
    seq = '{8'h32};
    send_seq(seq, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      word = $urandom;
      case (phase)
        1, 3:    word[0] = 1'b1;
        4:       word[0] = 1'($urandom_range(0, 1));
        default: word[0] = 1'b0;
      endcase
      write_reg(utf8ss_pkg::REG_TRUNCATE_ADDR, word);
      tx_idle = (phase != 1) && (phase != 5);
      rx_idle = (phase != 3) && (phase != 5);
      goal = bytes_sent + 80;
      if (phase == 2) begin
        // Keep feeding bytes while the output is held so the block backs up.
        long_hold_req <= 1'b1;
        tx_idle = 1'b0;
        while (bytes_sent < goal - 40) send_random_string(8);
        tx_idle = 1'b1;
      end
      while (bytes_sent < goal) begin
        send_random_string(phase == 4 ? 30 : 10);
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
